// File: src/vln_pkg.sv
// Package for the 2D vector length/normalize block: widths, defaults and stage types.
`timescale 1ns / 1ps
`default_nettype none
package vln_pkg;
   localparam int FRAC_BITS_DEF = 12;
   localparam int COMP_W        = 16;
   localparam int SQ_W          = 32;
   localparam int LEN_W         = 16;
   localparam int UNIT_W        = 14;
   localparam int REM_W         = LEN_W + 1;
   localparam logic [LEN_W-1:0] MIN_LENGTH_RST = LEN_W'(1);

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [LEN_W-1:0] root;
      logic [SQ_W-1:0]  rad;
   } sqrt_type;

   typedef struct packed {
      logic              valid;
      logic [SQ_W-1:0]   sq;
      logic [COMP_W-1:0] ax;
      logic [COMP_W-1:0] ay;
      logic              sx;
      logic              sy;
   } sq_side_type;

   typedef struct packed {
      logic             valid;
      logic [SQ_W-1:0]  sq;
      logic [LEN_W-1:0] len;
      logic             degen;
      logic             sx;
      logic             sy;
   } dv_side_type;
endpackage
`default_nettype wire

// File: src/vln_sqrt_cell.sv
// Square root cell: resolves one root bit from two radicand bits per cycle while en is high.
`timescale 1ns / 1ps
`default_nettype none
module vln_sqrt_cell (
   input  wire logic              clock,
   input  wire logic              en,
   input  wire vln_pkg::sqrt_type src,
   output vln_pkg::sqrt_type      dst
);
   import vln_pkg::*;

   logic [REM_W+1:0] rem_sh;
   logic [REM_W+1:0] trial;
   sqrt_type         q_in;
   sqrt_type         q_ff;

   always_comb begin
      rem_sh = {src.rem, src.rad[SQ_W-1 -: 2]};
      trial  = {1'b0, src.root, 2'b01};
      q_in.rad = {src.rad[SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
         q_in.rem  = REM_W'(rem_sh - trial);
         q_in.root = {src.root[LEN_W-2:0], 1'b1};
      end else begin
         q_in.rem  = rem_sh[REM_W-1:0];
         q_in.root = {src.root[LEN_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q_ff <= q_in;
      end
   end

   assign dst = q_ff;
endmodule
`default_nettype wire

// File: src/vln_div_cell.sv
// Division cell: one quotient bit for each of the two components per cycle while en is high.
`timescale 1ns / 1ps
`default_nettype none
module vln_div_cell #(
   parameter int QW = vln_pkg::FRAC_BITS_DEF + 1
) (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [vln_pkg::LEN_W-1:0]  src_len,
   input  wire logic [vln_pkg::LEN_W-1:0]  src_rem_x,
   input  wire logic [vln_pkg::LEN_W-1:0]  src_rem_y,
   input  wire logic                       src_feed_x,
   input  wire logic                       src_feed_y,
   input  wire logic [QW-1:0]              src_q_x,
   input  wire logic [QW-1:0]              src_q_y,
   output logic [vln_pkg::LEN_W-1:0]       dst_len,
   output logic [vln_pkg::LEN_W-1:0]       dst_rem_x,
   output logic [vln_pkg::LEN_W-1:0]       dst_rem_y,
   output logic                            dst_feed_x,
   output logic                            dst_feed_y,
   output logic [QW-1:0]                   dst_q_x,
   output logic [QW-1:0]                   dst_q_y
);
   import vln_pkg::*;

   logic [LEN_W:0]   sh_x;
   logic [LEN_W:0]   sh_y;
   logic             ge_x;
   logic             ge_y;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] rem_x_ff, rem_x_in;
   logic [LEN_W-1:0] rem_y_ff, rem_y_in;
   logic [QW-1:0]    q_x_ff, q_y_ff;

   always_comb begin
      sh_x = {src_rem_x, src_feed_x};
      sh_y = {src_rem_y, src_feed_y};
      ge_x = sh_x >= {1'b0, src_len};
      ge_y = sh_y >= {1'b0, src_len};
      rem_x_in = ge_x ? LEN_W'(sh_x - {1'b0, src_len}) : sh_x[LEN_W-1:0];
      rem_y_in = ge_y ? LEN_W'(sh_y - {1'b0, src_len}) : sh_y[LEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         len_ff   <= src_len;
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         q_x_ff   <= {src_q_x[QW-2:0], ge_x};
         q_y_ff   <= {src_q_y[QW-2:0], ge_y};
      end
   end

   assign dst_len    = len_ff;
   assign dst_rem_x  = rem_x_ff;
   assign dst_rem_y  = rem_y_ff;
   assign dst_feed_x = 1'b0;
   assign dst_feed_y = 1'b0;
   assign dst_q_x    = q_x_ff;
   assign dst_q_y    = q_y_ff;
endmodule
`default_nettype wire

// File: src/vector2_length_normalize.sv
// Top level: 2D vector squared length, length and unit vector in fixed point.
//
// Usage: a request carries x and y (signed, FRAC_BITS fraction bits) on
// req_valid/req_ready. Each request yields one response on rsp_valid/rsp_ready
// with the squared length, the floor square root length, the unit vector and
// a degenerate flag (length below csr min_length, or zero).
// The datapath is a row of cells: two squaring stages, 16 square root cells
// (one root bit each) and FRAC_BITS+1 division cells (one quotient bit each),
// then the response register. One request is taken every cycle while
// req_ready is high. The whole row advances together; when rsp_valid is high
// and rsp_ready low the row holds and req_ready drops, and it resumes the
// cycle rsp_ready returns. csr_wr_en writes min_length, to be used while idle.
// Reset clears all valid flags and sets min_length to 1.
`timescale 1ns / 1ps
`default_nettype none
module vector2_length_normalize #(
   parameter int FRAC_BITS = vln_pkg::FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [vln_pkg::COMP_W-1:0] req_x_in,
   input  wire logic signed [vln_pkg::COMP_W-1:0] req_y_in,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [vln_pkg::SQ_W-1:0]           rsp_length_sq,
   output logic [vln_pkg::LEN_W-1:0]          rsp_length,
   output logic signed [vln_pkg::UNIT_W-1:0]  rsp_unit_x,
   output logic signed [vln_pkg::UNIT_W-1:0]  rsp_unit_y,
   output logic                               rsp_degenerate,
   input  wire logic                          csr_wr_en,
   input  wire logic [vln_pkg::LEN_W-1:0]     csr_wr_data
);
   import vln_pkg::*;

   localparam int QW    = FRAC_BITS + 1;
   localparam int EW    = (QW + 1 > UNIT_W) ? QW + 1 : UNIT_W;
   localparam int NSQRT = LEN_W;

   logic             adv;
   logic [LEN_W-1:0] min_length_ff;

   // squaring stages
   logic [COMP_W-1:0] ax_in, ay_in;
   logic [SQ_W-1:0]   px_ff, py_ff;
   logic              pv_ff;
   logic [COMP_W-1:0] pax_ff, pay_ff;
   logic              psx_ff, psy_ff;

   sqrt_type    sqc [0:NSQRT];
   sq_side_type sqs [0:NSQRT];

   dv_side_type      dvs   [0:QW];
   logic [LEN_W-1:0] dlen  [0:QW];
   logic [LEN_W-1:0] drx   [0:QW];
   logic [LEN_W-1:0] dry   [0:QW];
   logic             dfx   [0:QW];
   logic             dfy   [0:QW];
   logic [QW-1:0]    dqx   [0:QW];
   logic [QW-1:0]    dqy   [0:QW];
   logic [LEN_W-1:0] root_len;

   logic [EW-1:0]     ex, ey, vx, vy;
   logic              rsp_valid_ff;
   logic [SQ_W-1:0]   length_sq_ff;
   logic [LEN_W-1:0]  length_ff;
   logic [UNIT_W-1:0] unit_x_ff, unit_y_ff;
   logic              degen_ff;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LENGTH_RST;
      end else if (csr_wr_en) begin
         min_length_ff <= csr_wr_data;
      end
   end

   assign ax_in = req_x_in[COMP_W-1] ? COMP_W'(-req_x_in) : req_x_in;
   assign ay_in = req_y_in[COMP_W-1] ? COMP_W'(-req_y_in) : req_y_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
      end else if (adv) begin
         pv_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         px_ff  <= ax_in * ax_in;
         py_ff  <= ay_in * ay_in;
         pax_ff <= ax_in;
         pay_ff <= ay_in;
         psx_ff <= req_x_in[COMP_W-1];
         psy_ff <= req_y_in[COMP_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sqs[0] <= '0;
      end else if (adv) begin
         sqs[0].valid <= pv_ff;
         sqs[0].sq    <= px_ff + py_ff;
         sqs[0].ax    <= pax_ff;
         sqs[0].ay    <= pay_ff;
         sqs[0].sx    <= psx_ff;
         sqs[0].sy    <= psy_ff;
      end
   end

   always_comb begin
      sqc[0].rem  = '0;
      sqc[0].root = '0;
      sqc[0].rad  = sqs[0].sq;
   end

   for (genvar i = 0; i < NSQRT; i++) begin : g_sqrt
      vln_sqrt_cell u_cell (
         .clock (clock),
         .en    (adv),
         .src   (sqc[i]),
         .dst   (sqc[i+1])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            sqs[i+1] <= '0;
         end else if (adv) begin
            sqs[i+1] <= sqs[i];
         end
      end
   end

   assign root_len = sqc[NSQRT].root;

   always_comb begin
      dvs[0].valid = sqs[NSQRT].valid;
      dvs[0].sq    = sqs[NSQRT].sq;
      dvs[0].len   = root_len;
      dvs[0].degen = (root_len < min_length_ff) || (root_len == '0);
      dvs[0].sx    = sqs[NSQRT].sx;
      dvs[0].sy    = sqs[NSQRT].sy;
      dlen[0]      = root_len;
      drx[0]       = {1'b0, sqs[NSQRT].ax[COMP_W-1:1]};
      dry[0]       = {1'b0, sqs[NSQRT].ay[COMP_W-1:1]};
      dfx[0]       = sqs[NSQRT].ax[0];
      dfy[0]       = sqs[NSQRT].ay[0];
      dqx[0]       = '0;
      dqy[0]       = '0;
   end

   for (genvar j = 0; j < QW; j++) begin : g_div
      vln_div_cell #(.QW(QW)) u_cell (
         .clock      (clock),
         .en         (adv),
         .src_len    (dlen[j]),
         .src_rem_x  (drx[j]),
         .src_rem_y  (dry[j]),
         .src_feed_x (dfx[j]),
         .src_feed_y (dfy[j]),
         .src_q_x    (dqx[j]),
         .src_q_y    (dqy[j]),
         .dst_len    (dlen[j+1]),
         .dst_rem_x  (drx[j+1]),
         .dst_rem_y  (dry[j+1]),
         .dst_feed_x (dfx[j+1]),
         .dst_feed_y (dfy[j+1]),
         .dst_q_x    (dqx[j+1]),
         .dst_q_y    (dqy[j+1])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            dvs[j+1] <= '0;
         end else if (adv) begin
            dvs[j+1] <= dvs[j];
         end
      end
   end

   always_comb begin
      ex = EW'(dqx[QW]);
      ey = EW'(dqy[QW]);
      vx = dvs[QW].sx ? EW'(-ex) : ex;
      vy = dvs[QW].sy ? EW'(-ey) : ey;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dvs[QW].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         length_sq_ff <= dvs[QW].sq;
         length_ff    <= dvs[QW].len;
         degen_ff     <= dvs[QW].degen;
         unit_x_ff    <= dvs[QW].degen ? '0 : vx[UNIT_W-1:0];
         unit_y_ff    <= dvs[QW].degen ? '0 : vy[UNIT_W-1:0];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_length_sq  = length_sq_ff;
   assign rsp_length     = length_ff;
   assign rsp_unit_x     = unit_x_ff;
   assign rsp_unit_y     = unit_y_ff;
   assign rsp_degenerate = degen_ff;

`ifndef SYNTH
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_unit_x == '0 && rsp_unit_y == '0)
      else $error("degenerate response with nonzero unit vector");
   a_nondegen_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |-> rsp_length != '0 && rsp_length >= min_length_ff)
      else $error("non-degenerate response below minimum length");
   a_root_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_length} * {1'b0, rsp_length}) <= {2'b00, rsp_length_sq})
      else $error("length too large for squared length");
   a_root_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_length} + 17'd1) * ({1'b0, rsp_length} + 17'd1)
                    > {2'b00, rsp_length_sq})
      else $error("length too small for squared length");
`endif
endmodule
`default_nettype wire
